>>> rtl/pcs_pkg.sv
// Shared types, constants and command/state encodings for the contrast stretch block.
package pcs_pkg;

  localparam int NUM_CH    = 4;
  localparam int CH_W      = 8;
  localparam int DIV_STEPS = CH_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef logic [CH_W-1:0] chan_t;
  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  localparam chan_t CHAN_MAX = '1;
  localparam chan_t CHAN_MIN = '0;

  typedef enum logic {
    REQ_MEASURE = 1'b0,
    REQ_RESCALE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } pcs_state_t;

  typedef struct packed {
    logic take_measure;
    logic take_rescale;
    logic div_step;
    logic out_load;
  } pcs_cmd_t;

endpackage

>>> rtl/pcs_if.sv
// Valid/ready channel interfaces for pixel requests and rescaled results.
interface pcs_in_if import pcs_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  req_type;
  logic  start_frame;
  chan_t in_alpha;
  chan_t in_red;
  chan_t in_green;
  chan_t in_blue;

  modport source (output valid, req_type, start_frame, in_alpha, in_red, in_green, in_blue,
                  input ready);
  modport sink (input valid, req_type, start_frame, in_alpha, in_red, in_green, in_blue,
                output ready);
endinterface

interface pcs_out_if import pcs_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t out_alpha;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;

  modport source (output valid, out_alpha, out_red, out_green, out_blue, input ready);
  modport sink (input valid, out_alpha, out_red, out_green, out_blue, output ready);
endinterface

>>> rtl/pcs_dp.sv
// Datapath: channel extrema, per-channel restoring dividers and result register.
module pcs_dp import pcs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  pcs_cmd_t cmd,
  input  logic     start_frame,
  input  pixel_t   pix_in,
  output pixel_t   pix_out
);

  pixel_t lo, hi;
  pixel_t lo_next, hi_next;
  pixel_t base_lo, base_hi;

  // divider state, one per channel
  pixel_t rem, nq, div;
  pixel_t rem_next, nq_next;
  pixel_t rem_load, nq_load, div_load;
  pixel_t force_val, force_val_next;
  logic [NUM_CH-1:0] force_en, force_en_next;

  always_comb begin
    logic              flat, below, above;
    chan_t             diff;
    logic [2*CH_W-1:0] num;
    logic [CH_W:0]     trial;
    logic              ge;
    for (int c = 0; c < NUM_CH; c++) begin
      // start flag clears extrema before the pixel is handled
      base_lo[c] = start_frame ? CHAN_MAX : lo[c];
      base_hi[c] = start_frame ? CHAN_MIN : hi[c];
      lo_next[c] = (pix_in[c] < base_lo[c]) ? pix_in[c] : base_lo[c];
      hi_next[c] = (pix_in[c] > base_hi[c]) ? pix_in[c] : base_hi[c];

      flat  = (base_hi[c] <= base_lo[c]);
      below = (pix_in[c] < base_lo[c]);
      above = (pix_in[c] > base_hi[c]);
      diff  = pix_in[c] - base_lo[c];
      // diff * 255 = (diff << 8) - diff
      num   = {diff, CHAN_MIN} - {CHAN_MIN, diff};
      rem_load[c]       = num[2*CH_W-1:CH_W];
      nq_load[c]        = num[CH_W-1:0];
      div_load[c]       = base_hi[c] - base_lo[c];
      force_en_next[c]  = flat | below | above;
      force_val_next[c] = (!flat && below) ? CHAN_MIN : CHAN_MAX;

      // one restoring step: remainder stays below divisor, quotient fits 8 bits
      trial = {rem[c], nq[c][CH_W-1]};
      ge    = (trial >= {1'b0, div[c]});
      rem_next[c] = ge ? CH_W'(trial - {1'b0, div[c]}) : trial[CH_W-1:0];
      nq_next[c]  = {nq[c][CH_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        lo[c] <= CHAN_MAX;
        hi[c] <= CHAN_MIN;
      end
    end else if (cmd.take_measure) begin
      lo <= lo_next;
      hi <= hi_next;
    end else if (cmd.take_rescale) begin
      lo <= base_lo;
      hi <= base_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_rescale) begin
      rem       <= rem_load;
      nq        <= nq_load;
      div       <= div_load;
      force_en  <= force_en_next;
      force_val <= force_val_next;
    end else if (cmd.div_step) begin
      rem <= rem_next;
      nq  <= nq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int c = 0; c < NUM_CH; c++) begin
        pix_out[c] <= force_en[c] ? force_val[c] : nq[c];
      end
    end
  end

endmodule

>>> rtl/pcs_ctrl.sv
// Controller: sequences accept, eight divide steps and result hand-off.
module pcs_ctrl import pcs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     req_type,
  input  logic     out_ready,
  output logic     in_ready,
  output logic     out_valid,
  output pcs_cmd_t cmd
);

  pcs_state_t       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;
  logic             out_free;
  logic             is_rescale;
  logic             last_step;

  assign out_free   = !out_valid || out_ready;
  assign is_rescale = (req_t'(req_type) == REQ_RESCALE);
  assign last_step  = (cnt == CNT_W'(DIV_STEPS - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid && is_rescale) state_next = ST_DIV;
      ST_DIV:  if (last_step) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = (state == ST_IDLE);
    cmd.take_measure = (state == ST_IDLE) && in_valid && !is_rescale;
    cmd.take_rescale = (state == ST_IDLE) && in_valid && is_rescale;
    cmd.div_step     = (state == ST_DIV);
    cmd.out_load     = (state == ST_DONE) && out_free;
  end

  always_comb begin
    cnt_next = (state == ST_DIV) ? cnt + 1'b1 : '0;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  a_rescale_starts_div: assert property (@(posedge clk) disable iff (rst)
    cmd.take_rescale |=> (state == ST_DIV) && (cnt == '0))
    else $error("rescale transaction did not start the divider");

  a_measure_stays_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take_measure |=> (state == ST_IDLE))
    else $error("measure transaction left idle");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) && last_step |=> (state == ST_DONE))
    else $error("divider did not finish after its last step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

endmodule

>>> rtl/per_channel_contrast_stretch_top.sv
// Top level of the per-channel min/max contrast stretch block.
//
// Channels: in_ch carries one pixel per transaction with req_type and
// start_frame; out_ch carries one rescaled pixel per rescale transaction.
// Usage: stream the image once with req_type = 0 (measure pass) to collect
// per-channel minima and maxima, then again with req_type = 1 (rescale
// pass). start_frame on a transaction resets all extrema (min 255, max 0)
// before that pixel is handled. Measure pixels give no result.
// Per channel: (v - min) * 255 / (max - min), truncated, saturated to
// 0..255; a flat or unmeasured channel (max <= min) gives 255.
// Sequence: a measure pixel is accepted and measured in the idle state. A
// rescale pixel goes through accept, 8 steps of the per-channel restoring
// divider (one quotient bit per step, four channels in parallel), then the
// result register load; the result shows on out_ch the cycle after that.
// Stall: the result register holds while out_ch.ready is low; a new pixel
// is still accepted and measured or divided meanwhile, and the next result
// waits in the divider until the register frees.
// Reset (rst, synchronous): extrema to 255/0, controller idle, no result.
module per_channel_contrast_stretch_top import pcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pcs_in_if.sink    in_ch,
  pcs_out_if.source out_ch
);

  pcs_cmd_t cmd;
  pixel_t   pix_in;
  pixel_t   pix_out;

  // channel 0 alpha, 1 red, 2 green, 3 blue
  assign pix_in = {in_ch.in_blue, in_ch.in_green, in_ch.in_red, in_ch.in_alpha};

  assign out_ch.out_alpha = pix_out[0];
  assign out_ch.out_red   = pix_out[1];
  assign out_ch.out_green = pix_out[2];
  assign out_ch.out_blue  = pix_out[3];

  pcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .req_type  (in_ch.req_type),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  pcs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .start_frame (in_ch.start_frame),
    .pix_in      (pix_in),
    .pix_out     (pix_out)
  );

endmodule
